// ===== rtl/double_ended_queue_assert.svh =====
// assertion macros for the double-ended queue
// expects clk and rst_n in the scope of each use
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define DQC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define DQC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dqc_pkg.sv =====
// shared types, constants and index helpers for the double-ended queue
// no dependencies
`default_nettype none

package dqc_pkg;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [OCC_W-1:0] occ_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // write request at the ring's access port
  typedef struct packed {
    logic  wr_en;
    word_t wr_data;
  } port_req_t;

  // what sits at the access port this cycle
  typedef struct packed {
    idx_t  addr;
    word_t data;
  } port_rsp_t;

  function automatic idx_t idx_up(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_down(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dqc_if.sv =====
// valid/ready channels for command items and result items
// depends on dqc_pkg
`default_nettype none

interface dqc_in_if;
  logic          valid;
  logic          ready;
  logic [1:0]    cmd;
  dqc_pkg::word_t push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface dqc_out_if;
  logic           valid;
  logic           ready;
  dqc_pkg::word_t pop_value;
  logic [1:0]     status;
  dqc_pkg::occ_t  occupancy;
  logic           is_empty;
  logic           is_full;

  modport source (output valid, output pop_value, output status, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input pop_value, input status, input occupancy,
                input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// bounded double-ended queue of signed words on a rotating ring of DEPTH cells
// refused items answer in the next cycle; others wait in the seek state for the
//   addressed word to rotate into cell 0 (the ring turns one place per cycle)
// one item in flight: refused items can be taken one per cycle while out_ch.ready holds;
//   the next item is taken only when the result register frees
// reset: synchronous active-low rst_n empties the queue; no clearing pass is needed
`default_nettype none

module double_ended_queue (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dqc_in_if.sink     in_ch,
  dqc_out_if.source  out_ch
);

  `include "double_ended_queue_assert.svh"

  localparam dqc_pkg::cnt_t CNT_FULL = dqc_pkg::cnt_t'(dqc_pkg::DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEEK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // queue pointers: head is the front word, tail is one past the back word
  dqc_pkg::idx_t head_r, head_nxt;
  dqc_pkg::idx_t tail_r, tail_nxt;
  dqc_pkg::cnt_t cnt_r, cnt_nxt;

  // item being worked on
  dqc_pkg::cmd_t  op_r, op_nxt;
  dqc_pkg::idx_t  tgt_r, tgt_nxt;
  dqc_pkg::word_t val_r, val_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  dqc_pkg::word_t   pop_value_r, pop_value_nxt;
  dqc_pkg::status_t status_r, status_nxt;
  dqc_pkg::cnt_t    res_cnt_r, res_cnt_nxt;

  dqc_pkg::port_req_t ring_req;
  dqc_pkg::port_rsp_t ring_rsp;

  logic           in_fire;
  logic           is_push;
  logic           refuse;
  dqc_pkg::cmd_t  in_cmd;
  dqc_pkg::idx_t  in_tgt;
  logic           hit;
  dqc_pkg::idx_t  tail_chk;
  logic [dqc_pkg::IDX_W:0] tail_sum;
  logic           done_idle;

  dqc_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .rsp   (ring_rsp)
  );

  // take a new item only when nothing is in flight and the result slot frees up
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;

  assign in_cmd  = dqc_pkg::cmd_t'(in_ch.cmd);
  assign is_push = (in_cmd == dqc_pkg::CMD_PUSH_FRONT) ||
                   (in_cmd == dqc_pkg::CMD_PUSH_BACK);
  assign refuse  = is_push ? (cnt_r == CNT_FULL) : (cnt_r == '0);

  // ring address each command touches
  always_comb begin
    unique case (in_cmd)
      dqc_pkg::CMD_PUSH_FRONT: in_tgt = dqc_pkg::idx_down(head_r);
      dqc_pkg::CMD_PUSH_BACK:  in_tgt = tail_r;
      dqc_pkg::CMD_POP_FRONT:  in_tgt = head_r;
      dqc_pkg::CMD_POP_BACK:   in_tgt = dqc_pkg::idx_down(tail_r);
      default:                 in_tgt = head_r;
    endcase
  end

  // addressed word sits in cell 0 this cycle
  assign hit = (state_r == S_SEEK) && (ring_rsp.addr == tgt_r);

  assign ring_req.wr_en = hit && ((op_r == dqc_pkg::CMD_PUSH_FRONT) ||
                                  (op_r == dqc_pkg::CMD_PUSH_BACK));
  assign ring_req.wr_data = val_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    tgt_nxt       = tgt_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pop_value_nxt = pop_value_r;
    status_nxt    = status_r;
    res_cnt_nxt   = res_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (refuse) begin
            // refused items answer at once and leave the queue untouched
            out_valid_nxt = 1'b1;
            pop_value_nxt = '0;
            status_nxt    = is_push ? dqc_pkg::ST_FULL : dqc_pkg::ST_EMPTY;
            res_cnt_nxt   = cnt_r;
          end else begin
            op_nxt    = in_cmd;
            tgt_nxt   = in_tgt;
            val_nxt   = in_ch.push_value;
            state_nxt = S_SEEK;
          end
        end
      end
      S_SEEK: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          status_nxt    = dqc_pkg::ST_OK;
          pop_value_nxt = '0;
          case (op_r)
            dqc_pkg::CMD_PUSH_FRONT: begin
              head_nxt = tgt_r;
              cnt_nxt  = dqc_pkg::cnt_t'(cnt_r + 1'b1);
            end
            dqc_pkg::CMD_PUSH_BACK: begin
              tail_nxt = dqc_pkg::idx_up(tgt_r);
              cnt_nxt  = dqc_pkg::cnt_t'(cnt_r + 1'b1);
            end
            dqc_pkg::CMD_POP_FRONT: begin
              head_nxt      = dqc_pkg::idx_up(tgt_r);
              cnt_nxt       = dqc_pkg::cnt_t'(cnt_r - 1'b1);
              pop_value_nxt = ring_rsp.data;
            end
            default: begin
              tail_nxt      = tgt_r;
              cnt_nxt       = dqc_pkg::cnt_t'(cnt_r - 1'b1);
              pop_value_nxt = ring_rsp.data;
            end
          endcase
          res_cnt_nxt = cnt_nxt;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    tgt_r       <= tgt_nxt;
    val_r       <= val_nxt;
    pop_value_r <= pop_value_nxt;
    status_r    <= status_nxt;
    res_cnt_r   <= res_cnt_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = pop_value_r;
  assign out_ch.status    = status_r;
  assign out_ch.occupancy = dqc_pkg::occ_t'(res_cnt_r);
  assign out_ch.is_empty  = (res_cnt_r == '0);
  assign out_ch.is_full   = (res_cnt_r == CNT_FULL);

  // head plus count, wrapped, must land on the tail
  assign tail_sum = {1'b0, head_r} + (dqc_pkg::IDX_W + 1)'(cnt_r % dqc_pkg::DEPTH);
  assign tail_chk = (tail_sum >= (dqc_pkg::IDX_W + 1)'(dqc_pkg::DEPTH)) ?
                    dqc_pkg::idx_t'(tail_sum - (dqc_pkg::IDX_W + 1)'(dqc_pkg::DEPTH)) :
                    dqc_pkg::idx_t'(tail_sum);

  // result waiting and ready for the next item
  assign done_idle = out_valid_r && (state_r == S_IDLE);

  `DQC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_FULL, "count above depth")
  `DQC_ASSERT_NOW(a_ptr_cnt, 1'b1, tail_chk == tail_r, "head, tail and count disagree")
  `DQC_ASSERT_NOW(a_seek_slot, state_r == S_SEEK, !out_valid_r, "result slot busy")
  `DQC_ASSERT_NEXT(a_refuse_out, in_fire && refuse, done_idle, "refused item gave no result")
  `DQC_ASSERT_NEXT(a_hit_done, hit, done_idle, "access did not complete")

endmodule

`default_nettype wire

// ===== rtl/dqc_cell.sv =====
// one storage cell of the rotating ring
// depends on dqc_pkg
`default_nettype none

module dqc_cell (
  input  wire logic           clk,
  input  wire dqc_pkg::word_t shift_in,
  input  wire logic           load_en,
  input  wire dqc_pkg::word_t load_data,
  output dqc_pkg::word_t      q
);

  dqc_pkg::word_t data_r;
  dqc_pkg::word_t data_nxt;

  always_comb begin
    data_nxt = load_en ? load_data : shift_in;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

// ===== rtl/dqc_ring.sv =====
// ring of cells rotating one place per cycle, accessed at cell 0
// depends on dqc_pkg and dqc_cell
`default_nettype none

module dqc_ring (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dqc_pkg::port_req_t  req,
  output dqc_pkg::port_rsp_t       rsp
);

  localparam int unsigned N = dqc_pkg::DEPTH;

  dqc_pkg::word_t cell_q [N];
  dqc_pkg::idx_t  phase_r;
  dqc_pkg::idx_t  phase_nxt;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int unsigned NEXT = (i + 1) % N;
    localparam bit IS_LAST = (i == N - 1);
    logic load_en;
    // the word leaving cell 0 enters the last cell, replaced on a write
    assign load_en = IS_LAST ? req.wr_en : 1'b0;
    dqc_cell u_cell (
      .clk       (clk),
      .shift_in  (cell_q[NEXT]),
      .load_en   (load_en),
      .load_data (req.wr_data),
      .q         (cell_q[i])
    );
  end

  // address of the word now in cell 0
  always_comb begin
    phase_nxt = dqc_pkg::idx_up(phase_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign rsp.addr = phase_r;
  assign rsp.data = cell_q[0];

endmodule

`default_nettype wire
